// File: rtl/core/rpat_pkg.sv
// Shared types, constants and gain tables for the relay autotuner.
package rpat_pkg;

  // Default sample and gain fraction widths
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Serial multiply/divide datapath widths
  localparam int NUM_W = 72;     // widest product a*b
  localparam int MB_W  = 33;     // multiplier operand b
  localparam int DEN_W = 49;     // widest divisor
  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = 7;      // counts up to NUM_W iterations

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_DRV_LO = 3'd1,
    REG_DRV_HI = 3'd2,
    REG_RULE   = 3'd3,
    REG_TOTAL  = 3'd4
  } cfg_reg_e;

  // Tuning rules; the unused code behaves as basic
  typedef enum logic [1:0] {
    RULE_BASIC = 2'd0,
    RULE_LESS  = 2'd1,
    RULE_NONE  = 2'd2
  } rule_e;

  localparam logic [7:0] CYCLE_TOTAL_RST = 8'd10;

  typedef struct packed {
    logic [15:0] drive_low;
    logic [15:0] drive_high;
    logic [1:0]  rule;
    logic [7:0]  total;
  } cfg_t;

  typedef struct packed {
    logic             mul;
    logic [NUM_W-1:0] a;
    logic [MB_W-1:0]  b;
    logic [DEN_W-1:0] c;
  } md_req_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_EVAL,
    CS_PREP,
    CS_KP,
    CS_KI,
    CS_KD,
    CS_AVGP,
    CS_AVGI,
    CS_AVGD,
    CS_DONE
  } core_state_t;

  // kc numerator
  function automatic logic [5:0] kc_num(input logic [1:0] rule);
    case (rule)
      RULE_LESS: kc_num = 6'd33;
      RULE_NONE: kc_num = 6'd1;
      default:   kc_num = 6'd3;
    endcase
  endfunction

  // kc denominator times pi in Q16
  function automatic logic [24:0] kc_pi(input logic [1:0] rule);
    case (rule)
      RULE_LESS: kc_pi = 25'd20588700;
      default:   kc_pi = 25'd1029435;
    endcase
  endfunction

  function automatic logic [5:0] td_num(input logic [1:0] rule);
    case (rule)
      RULE_LESS, RULE_NONE: td_num = 6'd33;
      default:              td_num = 6'd1;
    endcase
  endfunction

  function automatic logic [6:0] td_den(input logic [1:0] rule);
    case (rule)
      RULE_LESS, RULE_NONE: td_den = 7'd100;
      default:              td_den = 7'd8;
    endcase
  endfunction

endpackage

// File: rtl/core/rpat_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
interface rpat_in_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [SAMPLE_BITS-1:0] measurement;
  logic [31:0]            time_ms;
  modport source (output valid, command, measurement, time_ms, input ready);
  modport sink   (input valid, command, measurement, time_ms, output ready);
endinterface

interface rpat_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive;
  logic        finished;
  logic [31:0] gain_p;
  logic [31:0] gain_i;
  logic [31:0] gain_d;
  modport source (output valid, drive, finished, gain_p, gain_i, gain_d, input ready);
  modport sink   (input valid, drive, finished, gain_p, gain_i, gain_d, output ready);
endinterface

interface rpat_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/rpat_cfg.sv
// Configuration register bank of the relay autotuner.
module rpat_cfg
  import rpat_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rpat_cfg_if.sink                      cfg_s,
  output logic signed [SAMPLE_BITS-1:0] target,
  output cfg_t                          cfg
);

  logic signed [SAMPLE_BITS-1:0] target_r;
  cfg_t                          cfg_r;

  assign cfg_s.ready = 1'b1;
  assign target      = target_r;
  assign cfg         = cfg_r;

  // Decode the index and capture the write word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r         <= '0;
      cfg_r.drive_low  <= '0;
      cfg_r.drive_high <= '0;
      cfg_r.rule       <= RULE_BASIC;
      cfg_r.total      <= CYCLE_TOTAL_RST;
    end else if (cfg_s.valid) begin
      case (cfg_reg_e'(cfg_s.index))
        REG_TARGET: target_r         <= cfg_s.data[SAMPLE_BITS-1:0];
        REG_DRV_LO: cfg_r.drive_low  <= cfg_s.data[15:0];
        REG_DRV_HI: cfg_r.drive_high <= cfg_s.data[15:0];
        REG_RULE:   cfg_r.rule       <= cfg_s.data[1:0];
        REG_TOTAL:  cfg_r.total      <= cfg_s.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/rpat_muldiv.sv
// Bit-serial saturating multiply-divide: floor(a*b/c) (floor(a/c) if !mul) clipped to 32 bits.
module rpat_muldiv
  import rpat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  md_req_t     req,
  output logic        done,
  output logic [31:0] q
);

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MB_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0] OVR_LIM  = CNT_W'(NUM_W - 32);

  md_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] a_r, acc_r;
  logic [MB_W-1:0]  b_r;
  logic [DEN_W-1:0] c_r;
  logic [REM_W-1:0] rem_r, sh;
  logic [31:0]      q_r, res_r;
  logic             over_r, done_r, ge, ovr_bit, last;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MD_IDLE: if (start) state_nxt = req.mul ? MD_MUL : MD_DIV;
      MD_MUL:  if (cnt_r == MUL_LAST) state_nxt = MD_DIV;
      MD_DIV:  if (cnt_r == DIV_LAST) state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  // One restoring division step
  always_comb begin
    sh      = {rem_r[REM_W-2:0], acc_r[NUM_W-1]};
    ge      = (sh >= {1'b0, c_r});
    ovr_bit = ge && (cnt_r < OVR_LIM);
    last    = (state_r == MD_DIV) && (cnt_r == DIV_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= last;
    end
  end

  // Optional shift-add multiply, then shift-subtract divide, one bit a cycle
  always_ff @(posedge clk) begin
    case (state_r)
      MD_IDLE: begin
        if (start) begin
          a_r    <= req.a;
          b_r    <= req.b;
          c_r    <= req.c;
          acc_r  <= req.mul ? '0 : req.a;
          rem_r  <= '0;
          q_r    <= '0;
          over_r <= 1'b0;
          cnt_r  <= '0;
        end
      end
      MD_MUL: begin
        acc_r <= {acc_r[NUM_W-2:0], 1'b0} + (b_r[MB_W-1] ? a_r : '0);
        b_r   <= {b_r[MB_W-2:0], 1'b0};
        cnt_r <= (cnt_r == MUL_LAST) ? '0 : cnt_r + 1'b1;
      end
      MD_DIV: begin
        rem_r  <= ge ? sh - {1'b0, c_r} : sh;
        acc_r  <= {acc_r[NUM_W-2:0], 1'b0};
        q_r    <= {q_r[30:0], ge};
        over_r <= over_r | ovr_bit;
        cnt_r  <= cnt_r + 1'b1;
        if (last) res_r <= (over_r || ovr_bit) ? '1 : {q_r[30:0], ge};
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign q    = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == MD_IDLE) else $error("muldiv started while busy");
  a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(state_r) == MD_DIV) else $error("done without divide");

endmodule

// File: rtl/core/relay_pid_autotuner_core.sv
// Relay autotuner top level: sample tracking, gain sequencing and output word.
// A start word or a sample without a rising switch goes from evaluation to the output
// word. A rising switch adds the kp, ki and kd computations, and finishing adds the
// three averages; all run on the one-bit-per-cycle multiply-divide unit. One sample
// word is in flight at a time.
// Reset (synchronous, rst_n low) clears all tracking state; no clearing pass.
module relay_pid_autotuner_core
  import rpat_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rpat_in_if.sink     in_s,
  rpat_out_if.source  out_m,
  rpat_cfg_if.sink    cfg_s
);

  localparam int S = SAMPLE_BITS;

  logic signed [S-1:0] target;
  cfg_t                cfg;

  core_state_t state_r, state_nxt;
  logic        launched_r;
  logic        cmd_r;
  logic signed [S-1:0] meas_r, peak_r, trough_r;
  logic [31:0] now_r, last_tick_r, fall_time_r, rise_time_r, high_span_r, low_span_r;
  logic        relay_on_r;
  logic [15:0] drive_now_r;
  logic [7:0]  cycle_count_r;
  logic [39:0] sum_p_r, sum_i_r, sum_d_r;
  logic [31:0] gain_p_r, gain_i_r, gain_d_r, kp_r, ki_r, dt_r;
  logic [32:0] tu_r;
  logic signed [S:0] amp_r;
  logic [21:0] numk_r;
  logic [DEN_W-1:0] den_r;
  logic [37:0] kdnum_r;
  logic [38:0] kdden_r;
  logic        num_bad_r, amp_bad_r, acc_en_r;
  logic        out_valid_r, out_fin_r;
  logic [15:0] out_drive_r;
  logic [31:0] out_p_r, out_i_r, out_d_r;

  logic        md_start, md_done, kp_skip, fin0, out_free;
  logic [31:0] md_q;
  md_req_t     md_req;
  logic [7:0]  avg_div;

  // Evaluation of one sample
  logic signed [S-1:0] pk1, tr1, pk2;
  logic        ev_fall, ev_on1, ev_rise;
  logic [31:0] ev_hs, ev_ft, ev_ls;
  logic signed [16:0] num17;

  rpat_cfg #(.SAMPLE_BITS(S)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_s  (cfg_s),
    .target (target),
    .cfg    (cfg)
  );

  rpat_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .req   (md_req),
    .done  (md_done),
    .q     (md_q)
  );

  assign fin0     = (cycle_count_r >= cfg.total);
  assign kp_skip  = num_bad_r || amp_bad_r;
  assign out_free = !out_valid_r || out_m.ready;
  assign avg_div  = (cfg.total > 8'd2) ? cfg.total - 8'd2 : 8'd0;
  assign num17    = $signed({1'b0, cfg.drive_high}) - $signed({1'b0, cfg.drive_low});

  // Track peak, trough and relay switching for the held sample
  always_comb begin
    pk1     = (meas_r > peak_r) ? meas_r : peak_r;
    tr1     = (meas_r < trough_r) ? meas_r : trough_r;
    ev_fall = relay_on_r && (meas_r > target);
    ev_on1  = relay_on_r && !ev_fall;
    pk2     = ev_fall ? target : pk1;
    ev_hs   = ev_fall ? now_r - rise_time_r : high_span_r;
    ev_ft   = ev_fall ? now_r : fall_time_r;
    ev_rise = !ev_on1 && (meas_r < target);
    ev_ls   = ev_rise ? now_r - ev_ft : low_span_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: if (in_s.valid) state_nxt = CS_EVAL;
      CS_EVAL: begin
        if (cmd_r)        state_nxt = CS_DONE;
        else if (fin0)    state_nxt = CS_AVGP;
        else if (ev_rise) state_nxt = CS_PREP;
        else              state_nxt = CS_DONE;
      end
      CS_PREP: state_nxt = CS_KP;
      CS_KP:   if (kp_skip || md_done) state_nxt = CS_KI;
      CS_KI:   if (md_done) state_nxt = CS_KD;
      CS_KD:   if (md_done) state_nxt = fin0 ? CS_AVGP : CS_DONE;
      CS_AVGP: if (md_done) state_nxt = CS_AVGI;
      CS_AVGI: if (md_done) state_nxt = CS_AVGD;
      CS_AVGD: if (md_done) state_nxt = CS_DONE;
      CS_DONE: if (out_free) state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  // Launch and operand selection for the multiply-divide unit
  always_comb begin
    md_start = 1'b0;
    md_req   = '0;
    case (state_r)
      CS_KP: begin
        md_start = !launched_r && !kp_skip;
        md_req.a = NUM_W'(numk_r) << (GAIN_FRAC_BITS + 16);
        md_req.c = den_r;
      end
      CS_KI: begin
        md_start = !launched_r;
        md_req.mul = 1'b1;
        md_req.a   = NUM_W'({kp_r, 1'b0});
        md_req.b   = MB_W'(dt_r);
        md_req.c   = DEN_W'(tu_r);
      end
      CS_KD: begin
        md_start = !launched_r;
        md_req.mul = 1'b1;
        md_req.a   = NUM_W'(kdnum_r);
        md_req.b   = tu_r;
        md_req.c   = DEN_W'(kdden_r);
      end
      CS_AVGP: begin
        md_start = !launched_r;
        md_req.a = NUM_W'(sum_p_r);
        md_req.c = DEN_W'(avg_div);
      end
      CS_AVGI: begin
        md_start = !launched_r;
        md_req.a = NUM_W'(sum_i_r);
        md_req.c = DEN_W'(avg_div);
      end
      CS_AVGD: begin
        md_start = !launched_r;
        md_req.a = NUM_W'(sum_d_r);
        md_req.c = DEN_W'(avg_div);
      end
      default: ;
    endcase
  end

  assign in_s.ready = (state_r == CS_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (md_done)       launched_r <= 1'b0;
      else if (md_start) launched_r <= 1'b1;
      if (state_r == CS_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_m.ready)               out_valid_r <= 1'b0;
    end
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_on_r    <= 1'b0;
      drive_now_r   <= '0;
      cycle_count_r <= '0;
      last_tick_r   <= '0;
      fall_time_r   <= '0;
      rise_time_r   <= '0;
      high_span_r   <= '0;
      low_span_r    <= '0;
      peak_r        <= {1'b1, {(S-1){1'b0}}};
      trough_r      <= {1'b0, {(S-1){1'b1}}};
      sum_p_r       <= '0;
      sum_i_r       <= '0;
      sum_d_r       <= '0;
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
    end else begin
      case (state_r)
        CS_EVAL: begin
          if (cmd_r) begin
            cycle_count_r <= '0;
            relay_on_r    <= 1'b1;
            drive_now_r   <= cfg.drive_high;
            fall_time_r   <= now_r;
            rise_time_r   <= now_r;
            last_tick_r   <= now_r;
            high_span_r   <= '0;
            low_span_r    <= '0;
            peak_r        <= {1'b1, {(S-1){1'b0}}};
            trough_r      <= {1'b0, {(S-1){1'b1}}};
            sum_p_r       <= '0;
            sum_i_r       <= '0;
            sum_d_r       <= '0;
          end else if (fin0) begin
            relay_on_r  <= 1'b0;
            drive_now_r <= cfg.drive_low;
          end else begin
            last_tick_r <= now_r;
            peak_r      <= pk2;
            fall_time_r <= ev_ft;
            high_span_r <= ev_hs;
            low_span_r  <= ev_ls;
            if (ev_rise) begin
              relay_on_r    <= 1'b1;
              drive_now_r   <= cfg.drive_high;
              rise_time_r   <= now_r;
              trough_r      <= target;
              cycle_count_r <= cycle_count_r + 8'd1;
            end else begin
              relay_on_r <= ev_on1;
              trough_r   <= tr1;
              if (ev_fall) drive_now_r <= cfg.drive_low;
            end
          end
        end
        CS_KD: begin
          if (md_done) begin
            gain_p_r <= kp_r;
            gain_i_r <= ki_r;
            gain_d_r <= md_q;
            if (acc_en_r) begin
              sum_p_r <= sum_p_r + 40'(kp_r);
              sum_i_r <= sum_i_r + 40'(ki_r);
              sum_d_r <= sum_d_r + 40'(md_q);
            end
            if (fin0) begin
              relay_on_r  <= 1'b0;
              drive_now_r <= cfg.drive_low;
            end
          end
        end
        CS_AVGP: if (md_done) gain_p_r <= md_q;
        CS_AVGI: if (md_done) gain_i_r <= md_q;
        CS_AVGD: if (md_done) gain_d_r <= md_q;
        default: ;
      endcase
    end
  end

  // Sample capture and gain operands
  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      cmd_r  <= in_s.command;
      meas_r <= in_s.measurement;
      now_r  <= in_s.time_ms;
    end
    if (state_r == CS_EVAL) begin
      dt_r     <= now_r - last_tick_r;
      tu_r     <= 33'(ev_hs) + 33'(ev_ls);
      amp_r    <= {pk2[S-1], pk2} - {tr1[S-1], tr1};
      acc_en_r <= (cycle_count_r > 8'd1);
    end
    if (state_r == CS_PREP) begin
      num_bad_r <= num17[16] || (num17 == 17'sd0);
      amp_bad_r <= (amp_r <= 0);
      numk_r    <= 22'(kc_num(cfg.rule)) * 22'(num17[15:0]);
      den_r     <= DEN_W'(kc_pi(cfg.rule)) * DEN_W'(amp_r[S-1:0]);
    end
    if (state_r == CS_KP) begin
      if (num_bad_r)      kp_r <= '0;
      else if (amp_bad_r) kp_r <= '1;
      else if (md_done)   kp_r <= md_q;
    end
    if (state_r == CS_KI) begin
      kdnum_r <= 38'(td_num(cfg.rule)) * 38'(kp_r);
      kdden_r <= 39'(td_den(cfg.rule)) * 39'(dt_r);
      if (md_done) ki_r <= md_q;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (state_r == CS_DONE && out_free) begin
      out_drive_r <= drive_now_r;
      out_fin_r   <= fin0;
      out_p_r     <= gain_p_r;
      out_i_r     <= gain_i_r;
      out_d_r     <= gain_d_r;
    end
  end

  assign out_m.valid    = out_valid_r;
  assign out_m.drive    = out_drive_r;
  assign out_m.finished = out_fin_r;
  assign out_m.gain_p   = out_p_r;
  assign out_m.gain_i   = out_i_r;
  assign out_m.gain_d   = out_d_r;

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_s.valid && in_s.ready |=> state_r == CS_EVAL) else $error("accept not evaluated");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == CS_KP || state_r == CS_KI || state_r == CS_KD ||
                state_r == CS_AVGP || state_r == CS_AVGI || state_r == CS_AVGD)
    else $error("muldiv result with no waiter");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == CS_DONE) else $error("stray output word");

endmodule
